@@ rtl/bses_pkg.sv @@
// shared types and constants for the bubble sort core
package bses_pkg;

  localparam int unsigned DATA_W = 32;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_FIRST,
    S_CMP,
    S_TAIL,
    S_EMIT
  } seq_state_t;

  // datapath controls for one cycle
  typedef struct packed {
    logic load;    // write an input beat into the store
    logic take;    // capture the first element of a pass into the carry register
    logic cmp;     // compare carry against read data, write back the smaller one
    logic tail;    // write the carry to the end of the pass
  } dp_ctrl_t;

endpackage

@@ rtl/bubble_sort_early_exit_core.sv @@
// top level of the bubble sort core with early termination
// Elements load one beat per cycle while start is high and busy is low; a beat
// with in_last set closes the set and starts the sort, and beats past the
// store capacity are dropped and flag every result of that set with
// out_truncated. Each sort pass reads the first element into the carry
// register, compares the carry against each following element and writes the
// carry to the end of the pass, through the single store port pair (one read,
// one write per cycle); passes shrink by one until a pass makes no swap or a
// pass of one compare ends. Emitting gives one result beat per cycle, each in
// the cycle after its store read. Results come out on out_strobe for exactly
// one cycle each and cannot be held off; busy rises in the cycle after the
// closing beat and falls in the cycle that carries the last result beat.
module bubble_sort_early_exit_core #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [bses_pkg::DATA_W-1:0]  in_value,
  input  logic                                in_last,
  output logic                                out_strobe,
  output logic signed [bses_pkg::DATA_W-1:0]  out_sorted_value,
  output logic                                out_last_res,
  output logic                                out_truncated
);
  import bses_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);

  dp_ctrl_t      ctrl;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          swap;

  // control sequencer
  bses_seq #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_last       (in_last),
    .swap          (swap),
    .busy          (busy),
    .ctrl          (ctrl),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .out_strobe    (out_strobe),
    .out_last_res  (out_last_res),
    .out_truncated (out_truncated)
  );

  // store and compare datapath
  bses_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk      (clk),
    .ctrl     (ctrl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .in_value (in_value),
    .rd_data  (out_sorted_value),
    .swap     (swap)
  );

endmodule

@@ rtl/bses_dp.sv @@
// element store with the carry register and compare used by each sort pass
module bses_dp #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                                   clk,
  input  bses_pkg::dp_ctrl_t                     ctrl,
  input  logic [$clog2(MAX_ELEMENTS)-1:0]        rd_addr,
  input  logic [$clog2(MAX_ELEMENTS)-1:0]        wr_addr,
  input  logic signed [bses_pkg::DATA_W-1:0]     in_value,
  output logic signed [bses_pkg::DATA_W-1:0]     rd_data,
  output logic                                   swap
);
  import bses_pkg::*;

  logic signed [DATA_W-1:0] mem [MAX_ELEMENTS];
  logic signed [DATA_W-1:0] rd_data_r;
  logic signed [DATA_W-1:0] cur_r;
  logic signed [DATA_W-1:0] cur_nxt;
  logic signed [DATA_W-1:0] wr_data;
  logic                     wr_en;

  // left element is greater: the pair swaps
  assign swap = ctrl.cmp && (cur_r > rd_data_r);

  // write data select
  always_comb begin
    wr_en   = ctrl.load | ctrl.cmp | ctrl.tail;
    wr_data = cur_r;
    if (ctrl.load) begin
      wr_data = in_value;
    end else if (ctrl.cmp) begin
      wr_data = swap ? rd_data_r : cur_r;
    end
  end

  // carry keeps the larger element as it bubbles up
  always_comb begin
    cur_nxt = cur_r;
    if (ctrl.take) begin
      cur_nxt = rd_data_r;
    end else if (ctrl.cmp) begin
      cur_nxt = swap ? cur_r : rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/bses_seq.sv @@
// load, pass and emit sequencer for the bubble sort core
module bses_seq #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              in_last,
  input  logic                              swap,
  output logic                              busy,
  output bses_pkg::dp_ctrl_t                ctrl,
  output logic [$clog2(MAX_ELEMENTS)-1:0]   rd_addr,
  output logic [$clog2(MAX_ELEMENTS)-1:0]   wr_addr,
  output logic                              out_strobe,
  output logic                              out_last_res,
  output logic                              out_truncated
);
  import bses_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ELEMENTS);

  seq_state_t    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] len_r, len_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic          swp_r, swp_nxt;
  logic          strobe_r, last_r, trunc_r;
  logic          strobe_nxt, last_nxt;
  logic          accept;
  logic          room;
  logic [CW-1:0] n_set;
  logic          idx_end;
  logic          pass_done;
  logic          emit_end;

  assign accept    = start && (state_r == S_IDLE);
  assign room      = count_r < CNT_MAX;
  assign n_set     = room ? count_r + CW'(1) : count_r;
  assign idx_end   = idx_r == len_r - AW'(1);
  assign pass_done = !swp_r || (len_r == AW'(1));
  assign emit_end  = (CW'(k_r) + CW'(1)) == count_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_last) begin
          state_nxt = (n_set == CW'(1)) ? S_EMIT : S_PRIME;
        end
      end
      S_PRIME: state_nxt = S_FIRST;
      S_FIRST: state_nxt = S_CMP;
      S_CMP: begin
        if (idx_end) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL:  state_nxt = pass_done ? S_EMIT : S_PRIME;
      S_EMIT: begin
        if (emit_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath controls and store addresses
  always_comb begin
    ctrl    = '0;
    rd_addr = '0;
    wr_addr = '0;
    case (state_r)
      S_IDLE: begin
        ctrl.load = accept && room;
        wr_addr   = count_r[AW-1:0];
      end
      S_PRIME: rd_addr = '0;
      S_FIRST: begin
        ctrl.take = 1'b1;
        rd_addr   = AW'(1);
      end
      S_CMP: begin
        ctrl.cmp = 1'b1;
        wr_addr  = idx_r;
        rd_addr  = idx_r + AW'(2);
      end
      S_TAIL: begin
        ctrl.tail = 1'b1;
        wr_addr   = len_r;
      end
      S_EMIT: rd_addr = k_r;
      default: ctrl = '0;
    endcase
  end

  // counters and flags
  always_comb begin
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    k_nxt      = k_r;
    swp_nxt    = swp_r;
    strobe_nxt = 1'b0;
    last_nxt   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          count_nxt = n_set;
          ovf_nxt   = ovf_r | !room;
          len_nxt   = AW'(n_set - CW'(1));
          k_nxt     = '0;
        end
      end
      S_PRIME: swp_nxt = 1'b0;
      S_FIRST: idx_nxt = '0;
      S_CMP: begin
        idx_nxt = idx_r + AW'(1);
        swp_nxt = swp_r | swap;
      end
      S_TAIL: begin
        len_nxt = len_r - AW'(1);
        k_nxt   = '0;
      end
      S_EMIT: begin
        strobe_nxt = 1'b1;
        last_nxt   = emit_end;
        k_nxt      = k_r + AW'(1);
        if (emit_end) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: count_nxt = count_r;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      swp_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      swp_r    <= swp_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // indexes and result flags
  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    idx_r   <= idx_nxt;
    k_r     <= k_nxt;
    last_r  <= last_nxt;
    trunc_r <= ovf_r;
  end

  assign busy          = state_r != S_IDLE;
  assign out_strobe    = strobe_r;
  assign out_last_res  = last_r;
  assign out_truncated = trunc_r;

  // a result beat only follows an emit cycle
  a_strobe_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> $past(state_r == S_EMIT))
    else $error("result beat without an emit cycle");

  // the fill count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("element count beyond capacity");

  // a compare never runs past the end of the pass
  a_cmp_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (idx_r < len_r))
    else $error("compare index past pass length");

  // the end of a pass either starts another one or emits
  a_tail_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAIL) |=> (state_r == S_PRIME || state_r == S_EMIT))
    else $error("bad state after pass end");

endmodule
